// File: sv/mcw_pkg.sv
// mcw_pkg: shared types and codes of the multi-client watchdog
// holds the queued word layout, operation codes and result status codes
// no dependencies
package mcw_pkg;

    // action field of an incoming word
    localparam logic [1:0] ACT_KICK = 2'd0;
    localparam logic [1:0] ACT_TICK = 2'd1;
    localparam logic [1:0] ACT_STOP = 2'd2;

    // operation after classification in the front end
    typedef logic [1:0] mcw_op_t;
    localparam mcw_op_t OP_NOP  = 2'd0;
    localparam mcw_op_t OP_KICK = 2'd1;
    localparam mcw_op_t OP_TICK = 2'd2;
    localparam mcw_op_t OP_STOP = 2'd3;

    // result status codes
    typedef logic [2:0] mcw_status_t;
    localparam mcw_status_t ST_OK      = 3'd0;
    localparam mcw_status_t ST_NEW     = 3'd1;
    localparam mcw_status_t ST_FULL    = 3'd2;
    localparam mcw_status_t ST_TIMEOUT = 3'd3;
    localparam mcw_status_t ST_STOP    = 3'd4;
    localparam mcw_status_t ST_HALTED  = 3'd5;

    localparam int ID_W   = 16;
    localparam int CODE_W = 6;
    localparam int TIME_W = 32;
    localparam int LIM_W  = 16;
    localparam int IDX_W  = 4;

    // one classified word in the queue between front and back
    typedef struct packed {
        mcw_op_t           op;
        logic [ID_W-1:0]   client_id;
        logic [CODE_W-1:0] signal_code;
    } mcw_item_t;

endpackage

// File: sv/mcw_ram.sv
// mcw_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies
module mcw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                  aclk,
    input  logic                                  wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                      wr_data,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                      rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// File: sv/mcw_front.sv
// mcw_front: accepts input words, classifies the action and queues them
// depends on mcw_pkg
module mcw_front import mcw_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [1:0]        s_action,
    input  logic [ID_W-1:0]   s_client_id,
    input  logic [CODE_W-1:0] s_signal_code,
    output logic              head_valid,
    output mcw_item_t         head_item,
    input  logic              head_pop
);

    mcw_item_t  buf_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] fill_reg;
    mcw_item_t  item_in;
    logic       push;
    logic       pop;

    // classify the action
    always_comb begin
        item_in.client_id   = s_client_id;
        item_in.signal_code = s_signal_code;
        case (s_action)
            ACT_KICK: item_in.op = OP_KICK;
            ACT_TICK: item_in.op = OP_TICK;
            ACT_STOP: item_in.op = OP_STOP;
            default:  item_in.op = OP_NOP;
        endcase
    end

    assign s_ready    = (fill_reg != 2'd2);
    assign head_valid = (fill_reg != 2'd0);
    assign head_item  = buf_reg[rd_ptr_reg];
    assign push       = s_valid && s_ready;
    assign pop        = head_pop && head_valid;

    always_ff @(posedge aclk) begin
        if (push) begin
            buf_reg[wr_ptr_reg] <= item_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop) begin
                fill_reg <= fill_reg + 2'd1;
            end else if (pop && !push) begin
                fill_reg <= fill_reg - 2'd1;
            end
        end
    end

endmodule

// File: sv/mcw_back.sv
// mcw_back: executes queued words, walks the client table, holds the result register
// depends on mcw_pkg and mcw_ram
module mcw_back import mcw_pkg::*; #(
    parameter int MAX_CLIENTS = 16,
    parameter int ID_BITS     = 16
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_valid,
    input  logic [LIM_W-1:0]  cfg_data,
    input  logic              head_valid,
    input  mcw_item_t         head_item,
    output logic              head_pop,
    output logic              m_valid,
    input  logic              m_ready,
    output mcw_status_t       m_status,
    output logic [IDX_W-1:0]  m_entry_index,
    output logic              m_cancel_all,
    output logic [CODE_W-1:0] m_stop_code
);

    localparam int AW    = (MAX_CLIENTS > 1) ? $clog2(MAX_CLIENTS) : 1;
    localparam int CW    = $clog2(MAX_CLIENTS + 1);
    localparam int KEY_W = (ID_BITS < ID_W) ? ID_BITS : ID_W;
    localparam logic [CW-1:0] MAX_COUNT = CW'(MAX_CLIENTS);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_WALK = 1'b1;

    logic              state_reg;
    mcw_op_t           op_reg;
    logic [KEY_W-1:0]  key_reg;
    logic [LIM_W-1:0]  limit_reg;
    logic [TIME_W-1:0] time_now_reg;
    logic [CW-1:0]     count_reg;
    logic [CODE_W-1:0] pending_reg;
    logic              halted_reg;
    logic [CW-1:0]     rd_addr_reg;
    logic [CW-1:0]     cmp_idx_reg;
    logic              cmp_vld_reg;
    logic              m_valid_reg;
    mcw_status_t       status_reg;
    logic [IDX_W-1:0]  index_reg;
    logic              cancel_reg;
    logic [CODE_W-1:0] code_reg;

    logic [KEY_W-1:0]  id_q;
    logic [TIME_W-1:0] time_q;
    logic [TIME_W-1:0] age;
    logic              hit;
    logic              at_end;
    logic              walk_end;
    logic              full;
    logic              id_we;
    logic              time_we;
    logic [AW-1:0]     time_waddr;

    mcw_ram #(.WIDTH(KEY_W), .DEPTH(MAX_CLIENTS)) u_id_ram (
        .aclk    (aclk),
        .wr_en   (id_we),
        .wr_addr (count_reg[AW-1:0]),
        .wr_data (key_reg),
        .rd_addr (rd_addr_reg[AW-1:0]),
        .rd_data (id_q)
    );

    mcw_ram #(.WIDTH(TIME_W), .DEPTH(MAX_CLIENTS)) u_time_ram (
        .aclk    (aclk),
        .wr_en   (time_we),
        .wr_addr (time_waddr),
        .wr_data (time_now_reg),
        .rd_addr (rd_addr_reg[AW-1:0]),
        .rd_data (time_q)
    );

    // age taken modulo 2^32
    assign age      = time_now_reg - time_q;
    assign hit      = (op_reg == OP_TICK) ? (age > {{(TIME_W-LIM_W){1'b0}}, limit_reg})
                                          : (id_q == key_reg);
    assign at_end   = (cmp_idx_reg == count_reg);
    assign full     = (count_reg == MAX_COUNT);
    assign walk_end = (state_reg == S_WALK) && cmp_vld_reg && (at_end || hit);

    // table updates on the last walk cycle of a kick
    assign id_we      = walk_end && (op_reg == OP_KICK) && at_end && !full;
    assign time_we    = walk_end && (op_reg == OP_KICK) && !(at_end && full);
    assign time_waddr = at_end ? count_reg[AW-1:0] : cmp_idx_reg[AW-1:0];

    assign head_pop = (state_reg == S_IDLE) && head_valid && !m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            limit_reg    <= LIM_W'(2);
            time_now_reg <= '0;
            count_reg    <= '0;
            pending_reg  <= '0;
            halted_reg   <= 1'b0;
            cmp_vld_reg  <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (cfg_valid) begin
                limit_reg <= cfg_data;
            end
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (head_pop) begin
                        op_reg      <= head_item.op;
                        key_reg     <= head_item.client_id[KEY_W-1:0];
                        rd_addr_reg <= '0;
                        cmp_vld_reg <= 1'b0;
                        status_reg  <= ST_OK;
                        index_reg   <= '0;
                        cancel_reg  <= 1'b0;
                        code_reg    <= '0;
                        if (halted_reg) begin
                            status_reg  <= ST_HALTED;
                            m_valid_reg <= 1'b1;
                        end else begin
                            case (head_item.op)
                                OP_KICK: begin
                                    state_reg <= S_WALK;
                                end
                                OP_TICK: begin
                                    time_now_reg <= time_now_reg + TIME_W'(1);
                                    state_reg    <= S_WALK;
                                end
                                OP_STOP: begin
                                    pending_reg <= head_item.signal_code;
                                    m_valid_reg <= 1'b1;
                                end
                                default: begin
                                    m_valid_reg <= 1'b1;
                                end
                            endcase
                        end
                    end
                end
                S_WALK: begin
                    // ram address runs one entry ahead of the compare
                    rd_addr_reg <= rd_addr_reg + CW'(1);
                    cmp_idx_reg <= rd_addr_reg;
                    cmp_vld_reg <= 1'b1;
                    if (walk_end) begin
                        state_reg   <= S_IDLE;
                        cmp_vld_reg <= 1'b0;
                        m_valid_reg <= 1'b1;
                        if (op_reg == OP_KICK) begin
                            if (!at_end) begin
                                status_reg <= ST_OK;
                                index_reg  <= IDX_W'(cmp_idx_reg);
                            end else if (full) begin
                                status_reg <= ST_FULL;
                            end else begin
                                status_reg <= ST_NEW;
                                index_reg  <= IDX_W'(count_reg);
                                count_reg  <= count_reg + CW'(1);
                            end
                        end else begin
                            if (!at_end) begin
                                halted_reg <= 1'b1;
                                status_reg <= ST_TIMEOUT;
                                index_reg  <= IDX_W'(cmp_idx_reg);
                                cancel_reg <= 1'b1;
                            end else if (pending_reg != '0) begin
                                halted_reg <= 1'b1;
                                status_reg <= ST_STOP;
                                cancel_reg <= 1'b1;
                                code_reg   <= pending_reg;
                            end
                        end
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_status      = status_reg;
    assign m_entry_index = index_reg;
    assign m_cancel_all  = cancel_reg;
    assign m_stop_code   = code_reg;

endmodule

// File: sv/multi_client_watchdog.sv
// multi_client_watchdog: top level of the multi-client software watchdog
// depends on mcw_pkg, mcw_front, mcw_back and mcw_ram
//
//  channel   direction  handshake            payload
//  s_        in         s_valid / s_ready    s_action, s_client_id, s_signal_code
//  m_        out        m_valid / m_ready    m_status, m_entry_index, m_cancel_all,
//                                            m_stop_code
//  cfg_      in         cfg_valid/cfg_ready  cfg_data (timeout_limit)
//
// a kick or tick walks the client table between queue head and result, one ram
// read a cycle, and ends at the first hit or at the client count
// stop requests, unused actions and words to a halted block skip the walk
// until full, the two-entry queue takes words while the walk runs or a result waits
// synchronous active-low reset, no clearing pass: table entries are only read
// below the client count, which reset clears
module multi_client_watchdog import mcw_pkg::*; #(
    parameter int MAX_CLIENTS = 16,
    parameter int ID_BITS     = 16
) (
    input  logic              aclk,
    input  logic              aresetn,
    // configuration write
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [LIM_W-1:0]  cfg_data,
    // input words
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [1:0]        s_action,
    input  logic [ID_W-1:0]   s_client_id,
    input  logic [CODE_W-1:0] s_signal_code,
    // result words
    output logic              m_valid,
    input  logic              m_ready,
    output logic [2:0]        m_status,
    output logic [IDX_W-1:0]  m_entry_index,
    output logic              m_cancel_all,
    output logic [CODE_W-1:0] m_stop_code
);

    logic      head_valid;
    mcw_item_t head_item;
    logic      head_pop;

    // the limit register is always writable
    assign cfg_ready = 1'b1;

    // front end: accept, classify, queue
    mcw_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_action      (s_action),
        .s_client_id   (s_client_id),
        .s_signal_code (s_signal_code),
        .head_valid    (head_valid),
        .head_item     (head_item),
        .head_pop      (head_pop)
    );

    // back end: table walk, time base, halt logic and result register
    mcw_back #(
        .MAX_CLIENTS (MAX_CLIENTS),
        .ID_BITS     (ID_BITS)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_data      (cfg_data),
        .head_valid    (head_valid),
        .head_item     (head_item),
        .head_pop      (head_pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_entry_index (m_entry_index),
        .m_cancel_all  (m_cancel_all),
        .m_stop_code   (m_stop_code)
    );

`ifndef SYNTHESIS
    // cancel-all goes out exactly with a timeout or a stop
    a_cancel_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_cancel_all == ((m_status == ST_TIMEOUT) || (m_status == ST_STOP))))
        else $error("cancel_all disagrees with status");

    // a stop code is only reported with a stop status
    a_code_status: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_status != ST_STOP)) |-> (m_stop_code == '0))
        else $error("stop code outside a stop result");

    // the back end never pops an empty queue
    a_pop_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        head_pop |-> head_valid)
        else $error("pop from empty queue");

    // a new word is only taken from the queue once the result register is free
    a_pop_result_free: assert property (@(posedge aclk) disable iff (!aresetn)
        head_pop |=> !(m_valid && $past(m_valid)))
        else $error("result overwritten");
`endif

endmodule

// File: tb/tb_multi_client_watchdog.sv
`timescale 1ns / 1ps
// tb_multi_client_watchdog: self-checking bench for the multi-client watchdog
// holds a client-table predictor class and the top module
// depends on mcw_pkg and the multi_client_watchdog rtl

import mcw_pkg::*;

localparam int         SLOTS    = 16;
localparam logic [1:0] ACT_NONE = 2'd3;   // unused action code

typedef struct packed {
    mcw_status_t       status;
    logic [IDX_W-1:0]  entry;
    logic              cancel;
    logic [CODE_W-1:0] code;
} watch_reply_t;

// mirror of the client table, time base and halt state
class client_table_model;
    logic [LIM_W-1:0]  limit;
    logic [ID_W-1:0]   ids [SLOTS];
    logic [TIME_W-1:0] kicked_at [SLOTS];
    int unsigned       count;
    logic [TIME_W-1:0] now;
    logic [CODE_W-1:0] pending_code;
    bit                halted;
    watch_reply_t      expected_replies [$];
    int unsigned       errors;
    int unsigned       replies_seen [8];

    function new();
        limit        = 16'd2;
        count        = 0;
        now          = '0;
        pending_code = '0;
        halted       = 1'b0;
        errors       = 0;
        foreach (replies_seen[i]) replies_seen[i] = 0;
    endfunction

    // true when this slot would be too old after one more tick
    function bit goes_stale(int unsigned slot);
        logic [TIME_W-1:0] age;
        age = now + 1'b1 - kicked_at[slot];
        return age > {{(TIME_W-LIM_W){1'b0}}, limit};
    endfunction

    function watch_reply_t predict(logic [1:0] act, logic [ID_W-1:0] id,
                                   logic [CODE_W-1:0] code);
        watch_reply_t      r;
        logic [TIME_W-1:0] age;
        int unsigned       i;
        r        = '0;
        r.status = ST_OK;
        if (halted) begin
            r.status = ST_HALTED;
            return r;
        end
        case (act)
            ACT_KICK: begin
                for (i = 0; i < count; i++) begin
                    if (ids[i] == id) begin
                        kicked_at[i] = now;
                        r.entry      = IDX_W'(i);
                        return r;
                    end
                end
                if (count >= SLOTS) begin
                    r.status = ST_FULL;
                    return r;
                end
                ids[count]       = id;
                kicked_at[count] = now;
                r.status         = ST_NEW;
                r.entry          = IDX_W'(count);
                count++;
            end
            ACT_TICK: begin
                now = now + 1'b1;
                for (i = 0; i < count; i++) begin
                    age = now - kicked_at[i];
                    if (age > {{(TIME_W-LIM_W){1'b0}}, limit}) begin
                        halted   = 1'b1;
                        r.status = ST_TIMEOUT;
                        r.entry  = IDX_W'(i);
                        r.cancel = 1'b1;
                        return r;
                    end
                end
                if (pending_code != '0) begin
                    halted   = 1'b1;
                    r.status = ST_STOP;
                    r.cancel = 1'b1;
                    r.code   = pending_code;
                end
            end
            ACT_STOP: pending_code = code;
            default: ;
        endcase
        return r;
    endfunction

    function void accept_word(logic [1:0] act, logic [ID_W-1:0] id,
                              logic [CODE_W-1:0] code);
        expected_replies.push_back(predict(act, id, code));
    endfunction

    function void match_reply(mcw_status_t status, logic [IDX_W-1:0] entry,
                              logic cancel, logic [CODE_W-1:0] code);
        watch_reply_t want;
        if (expected_replies.size() == 0) begin
            $error("reply word with none outstanding: status %0d entry %0d", status, entry);
            errors++;
            return;
        end
        want = expected_replies.pop_front();
        replies_seen[want.status]++;
        if (status !== want.status) begin
            $error("status mismatch: expected %0d, actual %0d", want.status, status);
            errors++;
        end
        if (entry !== want.entry) begin
            $error("entry_index mismatch: expected %0d, actual %0d", want.entry, entry);
            errors++;
        end
        if (cancel !== want.cancel) begin
            $error("cancel_all mismatch: expected %0d, actual %0d", want.cancel, cancel);
            errors++;
        end
        if (code !== want.code) begin
            $error("stop_code mismatch: expected %0d, actual %0d", want.code, code);
            errors++;
        end
    endfunction
endclass

module tb_multi_client_watchdog;

    localparam int HALF_PERIOD   = 10;
    // settle time covers the longest walk over all SLOTS entries, plus some margin
    localparam int SETTLE_CYCLES = SLOTS + 8;
    localparam int STALL_LIMIT   = 4000;
    localparam int NO_PAUSE      = 32'h7FFF_FFFF;

    logic              aclk          = 1'b0;
    logic              aresetn       = 1'b0;
    logic              cfg_valid     = 1'b0;
    logic              cfg_ready;
    logic [LIM_W-1:0]  cfg_data      = '0;
    logic              s_valid       = 1'b0;
    logic              s_ready;
    logic [1:0]        s_action      = '0;
    logic [ID_W-1:0]   s_client_id   = '0;
    logic [CODE_W-1:0] s_signal_code = '0;
    logic              m_valid;
    logic              m_ready       = 1'b0;
    logic [2:0]        m_status;
    logic [IDX_W-1:0]  m_entry_index;
    logic              m_cancel_all;
    logic [CODE_W-1:0] m_stop_code;

    // when set, neither side idles
    bit                steady = 1'b0;
    client_table_model model  = new();

    int unsigned kicks_sent  = 0;
    int unsigned ticks_sent  = 0;
    int unsigned stops_sent  = 0;
    int unsigned noise_sent  = 0;
    int unsigned live_words  = 0;
    int unsigned stall_count = 0;
    string       halt_kind   = "nothing";

    multi_client_watchdog u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_action      (s_action),
        .s_client_id   (s_client_id),
        .s_signal_code (s_signal_code),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_entry_index (m_entry_index),
        .m_cancel_all  (m_cancel_all),
        .m_stop_code   (m_stop_code)
    );

    always #(HALF_PERIOD) aclk = ~aclk;

    // reply side: check each accepted word, stall about a third of the time
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            model.match_reply(m_status, m_entry_index, m_cancel_all, m_stop_code);
        m_ready <= steady || ($urandom_range(0, 99) >= 33);
    end

    // stall guard: any handshake restarts the count
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            stall_count <= 0;
        end else if (stall_count >= STALL_LIMIT) begin
            $display("no handshake for %0d cycles, %0d replies outstanding",
                     STALL_LIMIT, model.expected_replies.size());
            $display("tb_multi_client_watchdog: FAIL");
            $finish;
        end else begin
            stall_count <= stall_count + 1;
        end
    end

    // present one word, idling beforehand at random; valid stays up after
    // acceptance so back-to-back words need no second assignment
    task automatic send_word(input logic [1:0] act, input logic [ID_W-1:0] id,
                             input logic [CODE_W-1:0] code);
        while (!steady && $urandom_range(0, 99) < 33) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_action      <= act;
        s_client_id   <= id;
        s_signal_code <= code;
        do @(posedge aclk); while (!s_ready);
        model.accept_word(act, id, code);
        case (act)
            ACT_KICK: kicks_sent++;
            ACT_TICK: ticks_sent++;
            ACT_STOP: stops_sent++;
            default:  noise_sent++;
        endcase
        if (act != ACT_NONE)
            live_words++;
    endtask

    // hold the sender off until every reply is back
    task automatic drain_replies();
        s_valid <= 1'b0;
        do @(posedge aclk); while (model.expected_replies.size() != 0);
    endtask

    // timeout_limit only changes while the block is quiet
    task automatic write_limit(input logic [LIM_W-1:0] value);
        drain_replies();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid   <= 1'b0;
        model.limit = value;
    endtask

    // the signal code field is unused by a kick, so it carries noise
    task automatic kick(input logic [ID_W-1:0] id);
        send_word(ACT_KICK, id, CODE_W'($urandom));
    endtask

    // keep every client alive across the coming tick, then tick
    task automatic tick_alive();
        int unsigned i;
        for (i = 0; i < model.count; i++)
            if (model.goes_stale(i))
                kick(model.ids[i]);
        send_word(ACT_TICK, ID_W'($urandom), CODE_W'($urandom));
    endtask

    // a stop code is always cleared again before the next tick, otherwise
    // the block would halt for good
    task automatic stop_burst();
        if ($urandom_range(0, 3) == 0) begin
            send_word(ACT_STOP, ID_W'($urandom), '0);
        end else begin
            send_word(ACT_STOP, ID_W'($urandom), CODE_W'($urandom_range(1, 63)));
            if ($urandom_range(0, 2) == 0)
                send_word(ACT_STOP, ID_W'($urandom), CODE_W'($urandom_range(1, 63)));
            if ($urandom_range(0, 2) == 0 && model.count != 0)
                kick(model.ids[$urandom_range(0, model.count - 1)]);
            send_word(ACT_STOP, ID_W'($urandom), '0);
        end
    endtask

    // mostly known-client kicks and live ticks, with fresh ids filling the
    // table and then bouncing off it, stop bursts and a little noise
    task automatic run_phase(input int unsigned target, input int unsigned pause_at);
        int unsigned start;
        int unsigned pick;
        bit          paused;
        start  = live_words;
        paused = 1'b0;
        while (live_words - start < target) begin
            if (!paused && live_words - start >= pause_at) begin
                drain_replies();
                paused = 1'b1;
            end
            pick = $urandom_range(0, 99);
            if (pick < 45 && model.count != 0)
                kick(model.ids[$urandom_range(0, model.count - 1)]);
            else if (pick < 60)
                kick(ID_W'($urandom_range(0, 16'hFFFF)));
            else if (pick < 80)
                tick_alive();
            else if (pick < 94)
                stop_burst();
            else
                send_word(ACT_NONE, ID_W'($urandom), CODE_W'($urandom));
        end
    endtask

    // the halt is final until reset, so it closes the run: one victim ages
    // out (with or without a stop pending), or every client stays fresh and
    // a pending stop wins
    task automatic halt_block();
        int unsigned scenario;
        int unsigned victim;
        int unsigned rounds;
        int unsigned i;
        scenario = $urandom_range(0, 2);
        if (model.count == 0)
            kick(ID_W'($urandom));
        write_limit(LIM_W'($urandom_range(1, 4)));
        victim = $urandom_range(0, model.count - 1);
        if (scenario != 1)
            send_word(ACT_STOP, ID_W'($urandom), CODE_W'($urandom_range(1, 63)));
        rounds = 0;
        while (!model.halted && rounds < 8) begin
            for (i = 0; i < model.count; i++)
                if (scenario == 2 || i != victim)
                    kick(model.ids[i]);
            send_word(ACT_TICK, ID_W'($urandom), CODE_W'($urandom));
            rounds++;
        end
        case (scenario)
            0:       halt_kind = "timeout with a stop pending";
            1:       halt_kind = "timeout";
            default: halt_kind = "stop by signal";
        endcase
        // everything after the halt must answer halted
        repeat (20)
            send_word(2'($urandom_range(0, 3)), ID_W'($urandom), CODE_W'($urandom));
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // zero limit with an empty table: ticks are harmless, stop codes
        // latch and clear, the unused action is ignored
        write_limit(16'd0);
        send_word(ACT_TICK, 16'hFFFF, 6'h3F);
        send_word(ACT_STOP, 16'h0000, 6'd0);
        send_word(ACT_STOP, 16'hFFFF, 6'h3F);
        send_word(ACT_STOP, 16'h5555, 6'd0);
        send_word(ACT_NONE, 16'hFFFF, 6'h3F);
        send_word(ACT_TICK, 16'h0000, 6'd0);

        // widest limit: registration, repeat kicks, extreme ids
        write_limit(16'hFFFF);
        kick(16'h0000);
        kick(16'hFFFF);
        kick(16'h0000);
        send_word(ACT_TICK, 16'hAAAA, 6'h2A);
        kick(16'hFFFF);
        send_word(ACT_STOP, 16'h0F0F, 6'h2A);
        send_word(ACT_STOP, 16'hF0F0, 6'h15);
        kick(16'h8001);
        send_word(ACT_STOP, 16'h1234, 6'd0);
        send_word(ACT_TICK, 16'h5555, 6'h15);
        send_word(ACT_NONE, 16'h1234, 6'h00);

        // random phases over several limits; time wrap needs 2^32 ticks and
        // stays out of reach
        run_phase(350, NO_PAUSE);
        write_limit(LIM_W'($urandom_range(2, 8)));
        run_phase(400, 200);
        write_limit(16'd1);
        steady = 1'b1;
        run_phase(300, NO_PAUSE);
        steady = 1'b0;
        write_limit(LIM_W'($urandom_range(9, 40)));
        run_phase(330, NO_PAUSE);
        halt_block();

        drain_replies();
        repeat (SETTLE_CYCLES) @(posedge aclk);

        $display("covered %0d kicks, %0d ticks, %0d stop requests, %0d unused words",
                 kicks_sent, ticks_sent, stops_sent, noise_sent);
        $display("replies: %0d new, %0d table full, %0d halted; run closed by %s",
                 model.replies_seen[ST_NEW], model.replies_seen[ST_FULL],
                 model.replies_seen[ST_HALTED], halt_kind);
        if (model.errors == 0)
            $display("tb_multi_client_watchdog: PASS");
        else
            $display("tb_multi_client_watchdog: FAIL");
        $finish;
    end

endmodule
